// ----- design/dfsre_pkg.sv -----
// shared types, constants and helpers for the dfs room explorer
package dfsre_pkg;

    localparam int GRID_SIDE   = 64;
    localparam int STACK_DEPTH = 4096;

    localparam int POS_W     = $clog2(GRID_SIDE);
    localparam int MAP_DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int STK_AW    = $clog2(STACK_DEPTH);
    localparam int LVL_W     = $clog2(STACK_DEPTH + 1);
    localparam int EPOCH_W   = 4;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CMD_W     = 3;
    localparam int DIRS_W    = 3;
    localparam int MAX_RES   = 6;
    localparam int CNT_W     = $clog2(MAX_RES + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 1'd1;

    localparam logic [CMD_W-1:0] CMD_CLEAN = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MOVE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIN   = 3'd4;

    localparam logic [1:0] HD_NORTH = 2'd0;
    localparam logic [1:0] HD_WEST  = 2'd1;
    localparam logic [1:0] HD_SOUTH = 2'd2;
    localparam logic [1:0] HD_EAST  = 2'd3;

    typedef struct packed {
        logic op;
        logic move_ok;
    } t_in_word;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             last;
        logic             off_grid;
    } t_out_word;

    typedef struct packed {
        logic [MAX_RES-1:0][CMD_W-1:0] cmds;
        logic [CNT_W-1:0]              cnt;
        logic                          off_grid;
    } t_script;

    // row step for a heading, two's complement on POS_W+1 bits
    function automatic logic [POS_W:0] f_drow(input logic [1:0] hd);
        logic [POS_W:0] d;
        unique case (hd)
            HD_NORTH: d = '1;
            HD_SOUTH: d = (POS_W+1)'(1);
            default:  d = '0;
        endcase
        return d;
    endfunction

    function automatic logic [POS_W:0] f_dcol(input logic [1:0] hd);
        logic [POS_W:0] d;
        unique case (hd)
            HD_WEST: d = '1;
            HD_EAST: d = (POS_W+1)'(1);
            default: d = '0;
        endcase
        return d;
    endfunction

    function automatic logic [MAP_AW-1:0] f_map_addr(input logic [POS_W-1:0] row,
                                                     input logic [POS_W-1:0] col);
        return MAP_AW'(row * GRID_SIDE) + MAP_AW'(col);
    endfunction

endpackage

// ----- design/dfsre_out_buf.sv -----
// result buffer that holds one item's command words and hands them out in order
module dfsre_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  dfsre_pkg::t_script  i_script,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dfsre_pkg::t_out_word o_out_word
);

    logic [dfsre_pkg::MAX_RES-1:0][dfsre_pkg::CMD_W-1:0] r_cmds;
    logic [dfsre_pkg::CNT_W-1:0]                         r_cnt;
    logic                                                r_off;
    logic                                                w_take;

    assign o_out_valid = (r_cnt != '0);
    assign w_take      = o_out_valid && i_out_ready;
    assign o_free      = (r_cnt == '0) ||
                         ((r_cnt == dfsre_pkg::CNT_W'(1)) && w_take);

    assign o_out_word.command  = r_cmds[0];
    assign o_out_word.last     = (r_cnt == dfsre_pkg::CNT_W'(1));
    assign o_out_word.off_grid = r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_script.cnt;
        end else if (w_take) begin
            r_cnt <= r_cnt - dfsre_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmds <= i_script.cmds;
            r_off  <= i_script.off_grid;
        end else if (w_take) begin
            r_cmds <= r_cmds >> dfsre_pkg::CMD_W;
        end
    end

endmodule

// ----- design/dfs_room_explorer_unit.sv -----
// top level of the depth-first room exploration controller
// Each accepted word (start or reply to a move) is handled in order: first the
// visited map and the direction stack, both synchronous memories, are read; then,
// once the result buffer is free, state is updated and the commands are loaded. The
// commands, up to six per word, leave one word per cycle while the receiver is ready,
// through a result buffer, so the next word is taken while they drain. The visited
// map is tagged with a start count; after reset, on the sixteenth start and on every
// fifteenth start after that, a clearing pass over all 4096 map cells runs, during which no word is accepted.
module dfs_room_explorer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  dfsre_pkg::t_in_word             i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output dfsre_pkg::t_out_word            o_out_word,
    input  logic                            i_cfg_we,
    input  logic [dfsre_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dfsre_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int POS_W   = dfsre_pkg::POS_W;
    localparam int MAP_AW  = dfsre_pkg::MAP_AW;
    localparam int STK_AW  = dfsre_pkg::STK_AW;
    localparam int LVL_W   = dfsre_pkg::LVL_W;
    localparam int EPOCH_W = dfsre_pkg::EPOCH_W;
    localparam int DIRS_W  = dfsre_pkg::DIRS_W;
    localparam int CNT_W   = dfsre_pkg::CNT_W;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_FWD  = 2'd1;
    localparam logic [1:0] PH_BACK = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    logic [EPOCH_W-1:0] vis_mem [dfsre_pkg::MAP_DEPTH];
    logic [DIRS_W-1:0]  stk_mem [dfsre_pkg::STACK_DEPTH];

    logic [POS_W-1:0] w_mod_tab [2**dfsre_pkg::CFG_W];

    logic [dfsre_pkg::CFG_W-1:0] r_start_row;
    logic [dfsre_pkg::CFG_W-1:0] r_start_col;

    logic               r_busy;
    logic               r_op;
    logic               r_ok;
    logic [EPOCH_W-1:0] r_vis_tag;
    logic [DIRS_W-1:0]  r_stk_q;

    logic [1:0]         r_phase,   n_phase;
    logic [POS_W-1:0]   r_row,     n_row;
    logic [POS_W-1:0]   r_col,     n_col;
    logic [1:0]         r_heading, n_heading;
    logic [DIRS_W-1:0]  r_dirs,    n_dirs;
    logic [LVL_W-1:0]   r_level,   n_level;
    logic [EPOCH_W-1:0] r_epoch,   n_epoch;
    logic               r_clearing, n_clearing;
    logic [MAP_AW-1:0]  r_clr_addr;

    logic                 w_accept;
    logic                 w_commit;
    logic                 w_free;
    logic [POS_W:0]       w_nr;
    logic [POS_W:0]       w_nc;
    logic [MAP_AW-1:0]    w_tgt_addr;
    logic [MAP_AW-1:0]    w_cur_addr;
    logic [LVL_W-1:0]     w_pop_level;
    logic                 w_off;
    logic                 w_visited;
    logic                 w_full;

    logic                 v_nd;
    logic [DIRS_W-1:0]    v_dirs;
    logic [POS_W:0]       v_back_row;
    logic [POS_W:0]       v_back_col;
    logic [CNT_W-1:0]     v_cnt;
    logic                 v_vis_we;
    logic [MAP_AW-1:0]    v_vis_addr;
    logic                 v_stk_we;
    dfsre_pkg::t_script   v_script;

    for (genvar g = 0; g < 2**dfsre_pkg::CFG_W; g++) begin : g_mod
        assign w_mod_tab[g] = POS_W'(g % dfsre_pkg::GRID_SIDE);
    end

    assign o_in_ready = !r_busy && !r_clearing;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_commit   = r_busy && w_free;

    assign w_nr        = {1'b0, r_row} + dfsre_pkg::f_drow(r_heading);
    assign w_nc        = {1'b0, r_col} + dfsre_pkg::f_dcol(r_heading);
    assign w_tgt_addr  = dfsre_pkg::f_map_addr(w_nr[POS_W-1:0], w_nc[POS_W-1:0]);
    assign w_cur_addr  = dfsre_pkg::f_map_addr(r_row, r_col);
    assign w_pop_level = r_level - LVL_W'(1);
    assign w_off       = (w_nr >= (POS_W+1)'(dfsre_pkg::GRID_SIDE)) ||
                         (w_nc >= (POS_W+1)'(dfsre_pkg::GRID_SIDE));
    assign w_visited   = (r_vis_tag == r_epoch);
    assign w_full      = (r_level >= LVL_W'(dfsre_pkg::STACK_DEPTH));

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_row <= dfsre_pkg::CFG_W'(32);
            r_start_col <= dfsre_pkg::CFG_W'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dfsre_pkg::CFG_START_ROW: r_start_row <= i_cfg_data;
                dfsre_pkg::CFG_START_COL: r_start_col <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // commit: read-modify-write of the exploration state
    always_comb begin
        n_phase    = r_phase;
        n_row      = r_row;
        n_col      = r_col;
        n_heading  = r_heading;
        n_dirs     = r_dirs;
        n_level    = r_level;
        n_epoch    = r_epoch;
        n_clearing = r_clearing;
        v_nd       = 1'b0;
        v_dirs     = '0;
        v_back_row = '0;
        v_back_col = '0;
        v_cnt      = '0;
        v_vis_we   = 1'b0;
        v_vis_addr = w_tgt_addr;
        v_stk_we   = 1'b0;
        v_script   = '0;

        if (!r_op) begin
            n_row      = w_mod_tab[r_start_row];
            n_col      = w_mod_tab[r_start_col];
            n_heading  = dfsre_pkg::HD_NORTH;
            n_level    = '0;
            n_dirs     = DIRS_W'(4);
            n_phase    = PH_FWD;
            v_vis_we   = 1'b1;
            v_vis_addr = dfsre_pkg::f_map_addr(n_row, n_col);
            if (r_epoch == EPOCH_MAX) begin
                n_epoch    = EPOCH_W'(1);
                n_clearing = 1'b1;
            end else begin
                n_epoch = r_epoch + EPOCH_W'(1);
            end
            v_script.cmds[0] = dfsre_pkg::CMD_CLEAN;
            v_script.cmds[1] = dfsre_pkg::CMD_MOVE;
            v_cnt            = CNT_W'(2);
        end else if (r_phase == PH_FWD) begin
            if (r_ok) begin
                if (w_off || w_visited || w_full) begin
                    v_script.off_grid = w_off;
                    v_script.cmds[0]  = dfsre_pkg::CMD_RIGHT;
                    v_script.cmds[1]  = dfsre_pkg::CMD_RIGHT;
                    v_script.cmds[2]  = dfsre_pkg::CMD_MOVE;
                    v_cnt             = CNT_W'(3);
                    n_phase           = PH_BACK;
                end else begin
                    v_stk_we         = 1'b1;
                    v_vis_we         = 1'b1;
                    n_level          = r_level + LVL_W'(1);
                    n_row            = w_nr[POS_W-1:0];
                    n_col            = w_nc[POS_W-1:0];
                    n_dirs           = DIRS_W'(4);
                    v_script.cmds[0] = dfsre_pkg::CMD_CLEAN;
                    v_script.cmds[1] = dfsre_pkg::CMD_MOVE;
                    v_cnt            = CNT_W'(2);
                end
            end else begin
                v_nd = 1'b1;
            end
        end else if (r_phase == PH_BACK) begin
            v_script.cmds[0] = dfsre_pkg::CMD_RIGHT;
            v_script.cmds[1] = dfsre_pkg::CMD_RIGHT;
            v_cnt            = CNT_W'(2);
            v_nd             = 1'b1;
        end else begin
            v_script.cmds[0] = dfsre_pkg::CMD_FIN;
            v_cnt            = CNT_W'(1);
        end

        // turn to the next direction, or leave the cell when none is left
        if (v_nd) begin
            v_script.cmds[v_cnt] = dfsre_pkg::CMD_LEFT;
            v_cnt                = v_cnt + CNT_W'(1);
            n_heading            = r_heading + 2'd1;
            v_dirs               = (r_dirs != '0) ? r_dirs - DIRS_W'(1) : '0;
            n_dirs               = v_dirs;
            if (v_dirs != '0) begin
                v_script.cmds[v_cnt] = dfsre_pkg::CMD_MOVE;
                v_cnt                = v_cnt + CNT_W'(1);
                n_phase              = PH_FWD;
            end else if (r_level == '0) begin
                v_script.cmds[v_cnt] = dfsre_pkg::CMD_FIN;
                v_cnt                = v_cnt + CNT_W'(1);
                n_phase              = PH_DONE;
            end else begin
                n_level    = w_pop_level;
                n_dirs     = r_stk_q;
                v_back_row = {1'b0, r_row} - dfsre_pkg::f_drow(n_heading);
                v_back_col = {1'b0, r_col} - dfsre_pkg::f_dcol(n_heading);
                n_row      = v_back_row[POS_W-1:0];
                n_col      = v_back_col[POS_W-1:0];
                v_script.cmds[v_cnt] = dfsre_pkg::CMD_RIGHT;
                v_cnt                = v_cnt + CNT_W'(1);
                v_script.cmds[v_cnt] = dfsre_pkg::CMD_RIGHT;
                v_cnt                = v_cnt + CNT_W'(1);
                v_script.cmds[v_cnt] = dfsre_pkg::CMD_MOVE;
                v_cnt                = v_cnt + CNT_W'(1);
                n_phase              = PH_BACK;
            end
        end

        v_script.cnt = v_cnt;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_phase    <= PH_IDLE;
            r_row      <= '0;
            r_col      <= '0;
            r_heading  <= dfsre_pkg::HD_NORTH;
            r_dirs     <= '0;
            r_level    <= '0;
            r_epoch    <= '0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_commit) begin
                r_busy <= 1'b0;
            end
            if (w_commit) begin
                r_phase    <= n_phase;
                r_row      <= n_row;
                r_col      <= n_col;
                r_heading  <= n_heading;
                r_dirs     <= n_dirs;
                r_level    <= n_level;
                r_epoch    <= n_epoch;
                r_clearing <= n_clearing;
                r_clr_addr <= '0;
            end else if (r_clearing) begin
                if (r_clr_addr == MAP_AW'(dfsre_pkg::MAP_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + MAP_AW'(1);
            end
        end
    end

    // captured input word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_in_word.op;
            r_ok <= i_in_word.move_ok;
        end
    end

    // visited map: tag per cell, equal to the current start count when visited
    always_ff @(posedge i_clk) begin
        if (r_clearing && !w_commit) begin
            vis_mem[r_clr_addr] <= ((r_clr_addr == w_cur_addr) && (r_phase != PH_IDLE)) ?
                                   r_epoch : '0;
        end else if (w_commit && v_vis_we) begin
            vis_mem[v_vis_addr] <= n_epoch;
        end
        if (w_accept) begin
            r_vis_tag <= vis_mem[w_tgt_addr];
        end
    end

    // direction count stack
    always_ff @(posedge i_clk) begin
        if (w_commit && v_stk_we) begin
            stk_mem[r_level[STK_AW-1:0]] <= r_dirs;
        end
        if (w_accept) begin
            r_stk_q <= stk_mem[w_pop_level[STK_AW-1:0]];
        end
    end

    dfsre_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_commit),
        .i_script    (v_script),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
